FILE: sv/fqs_pkg.sv
`default_nettype none

package fqs_pkg;

   localparam int VALUE_W   = 32;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 5;
   localparam int INDEX_W   = 4;
   localparam int RSP_DATA_W = 80;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_ENQUEUE = 2'd0;
   localparam op_type OP_DEQUEUE = 2'd1;
   localparam op_type OP_SEARCH  = 2'd2;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_EMPTY    = 2'd1;
   localparam status_type ST_FULL     = 2'd2;
   localparam status_type ST_NOTFOUND = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic       accept;      // latch request, clear result
      logic       enq;         // write tail, bump count
      logic       deq;         // advance head, read new front
      logic       front_load;  // take read data as front
      logic       scan_start;  // read head entry
      logic       scan_step;   // read next entry
      logic       status_we;
      status_type status_code;
      logic       found_we;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   match;
      logic   last;
   } stat_type;

endpackage

`default_nettype wire

FILE: sv/fqs_ctrl.sv
`default_nettype none

module fqs_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire fqs_pkg::stat_type stat,
   output fqs_pkg::cmd_type      cmd
);
   import fqs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FRONT,
      S_SCAN,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      valid_ff, valid_in;

   always_comb begin
      cmd         = '0;
      cmd.status_code = ST_OK;
      state_in    = state_ff;
      ready_in    = ready_ff;
      valid_in    = valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.accept = 1'b1;
               ready_in   = 1'b0;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.status_we = 1'b1;
            unique case (stat.op)
               OP_ENQUEUE: begin
                  if (stat.full) begin
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.enq = 1'b1;
                  end
                  valid_in = 1'b1;
                  state_in = S_RESP;
               end
               OP_DEQUEUE: begin
                  if (stat.empty) begin
                     cmd.status_code = ST_EMPTY;
                     valid_in = 1'b1;
                     state_in = S_RESP;
                  end else begin
                     cmd.deq  = 1'b1;
                     state_in = S_FRONT;
                  end
               end
               OP_SEARCH: begin
                  if (stat.empty) begin
                     cmd.status_code = ST_EMPTY;
                     valid_in = 1'b1;
                     state_in = S_RESP;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  valid_in = 1'b1;
                  state_in = S_RESP;
               end
            endcase
         end
         S_FRONT: begin
            cmd.front_load = 1'b1;
            valid_in = 1'b1;
            state_in = S_RESP;
         end
         S_SCAN: begin
            // read data holds the entry at the compare index
            if (stat.match) begin
               cmd.status_we = 1'b1;
               cmd.found_we  = 1'b1;
               valid_in = 1'b1;
               state_in = S_RESP;
            end else if (stat.last) begin
               cmd.status_we   = 1'b1;
               cmd.status_code = ST_NOTFOUND;
               valid_in = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_RESP: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               ready_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            ready_in = 1'b1;
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;

endmodule

`default_nettype wire

FILE: sv/fqs_dpath.sv
`default_nettype none

module fqs_dpath #(
   parameter int DEPTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [fqs_pkg::OP_W-1:0]        req_tuser,
   input  wire logic [fqs_pkg::VALUE_W-1:0]     req_tdata,
   input  wire fqs_pkg::cmd_type                cmd,
   output fqs_pkg::stat_type                    stat,
   output logic [fqs_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [fqs_pkg::STATUS_W-1:0]         rsp_tuser
);
   import fqs_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
      next_slot = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   logic [VALUE_W-1:0] mem [DEPTH];

   logic [PW-1:0]      head_ff, head_in;
   logic [PW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [PW-1:0]      scan_ptr_ff;
   logic [CW-1:0]      cmp_idx_ff;
   logic [PW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data_ff;
   logic [VALUE_W-1:0] value_ff;
   op_type             op_ff;
   logic [VALUE_W-1:0] front_ff;
   logic [VALUE_W-1:0] rear_ff;
   status_type         status_ff;
   logic [INDEX_W-1:0] found_ff;
   logic [31:0]        count_ext;
   logic [31:0]        idx_ext;
   logic               is_empty;

   always_comb begin
      if (cmd.deq) begin
         rd_addr = next_slot(head_ff);
      end else if (cmd.scan_start) begin
         rd_addr = head_ff;
      end else begin
         rd_addr = scan_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.enq) begin
         mem[tail_ff] <= value_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.enq) begin
         tail_in  = next_slot(tail_ff);
         count_in = count_ff + CW'(1);
      end
      if (cmd.deq) begin
         head_in  = next_slot(head_ff);
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         value_ff  <= req_tdata;
         op_ff     <= req_tuser;
         status_ff <= ST_OK;
         found_ff  <= '0;
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.found_we) begin
         found_ff <= idx_ext[INDEX_W-1:0];
      end
      if (cmd.enq) begin
         rear_ff <= value_ff;
         if (count_ff == '0) begin
            front_ff <= value_ff;
         end
      end
      if (cmd.front_load) begin
         front_ff <= rd_data_ff;
      end
      if (cmd.scan_start) begin
         scan_ptr_ff <= next_slot(head_ff);
         cmp_idx_ff  <= '0;
      end
      if (cmd.scan_step) begin
         scan_ptr_ff <= next_slot(scan_ptr_ff);
         cmp_idx_ff  <= cmp_idx_ff + CW'(1);
      end
   end

   assign count_ext = 32'(count_ff);
   assign idx_ext   = 32'(cmp_idx_ff);
   assign is_empty  = (count_ff == '0);

   assign stat.op    = op_ff;
   assign stat.empty = is_empty;
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.match = (rd_data_ff == value_ff);
   assign stat.last  = (cmp_idx_ff == count_ff - CW'(1));

   assign rsp_tuser = status_ff;
   assign rsp_tdata = {6'd0,
                       found_ff,
                       count_ext[COUNT_W-1:0],
                       is_empty,
                       is_empty ? {VALUE_W{1'b0}} : rear_ff,
                       is_empty ? {VALUE_W{1'b0}} : front_ff};

endmodule

`default_nettype wire

FILE: sv/fifo_queue_with_search.sv
`default_nettype none

// Channel  | Dir | tuser          | tdata
// req_     | in  | [1:0] op       | [31:0] value
// rsp_     | out | [1:0] status   | [31:0] front, [63:32] rear, [64] is_empty,
//          |     |                | [69:65] entry_count, [73:70] found_index
//
// One request at a time. An enqueue passes S_EXEC before rsp_tvalid, a dequeue
// S_EXEC and S_FRONT, a search S_EXEC and then S_SCAN, which compares up to
// DEPTH entries: the scan reads one entry per cycle through the single read port.
// Reset clears pointers and count; the entry store needs no clearing.
// A stalled response holds the block; the next request is taken after the
// response transfer.

module fifo_queue_with_search #(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [1:0]  req_tuser,   // [1:0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // front, rear, is_empty, entry_count, found_index
   output logic [1:0]       rsp_tuser    // [1:0] status
);
   import fqs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   fqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fqs_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fqs_pkg::*;

   localparam int DEPTH        = 16;
   localparam op_type OP_NOP   = 2'd3;
   localparam int RANDOM_ITEMS = 1800;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_MAX   = 60;

   localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN_NEG = 32'h8000_0000;

   typedef struct packed {
      status_type  status;
      logic [31:0] front;
      logic [31:0] rear;
      logic        is_empty;
      logic [4:0]  count;
      logic [3:0]  found;
   } qresult_type;

   typedef struct {
      op_type      op;
      logic [31:0] value;
      bit          typed;
      qresult_type want;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] value
   logic [1:0]  req_tuser  = '0;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;         // [31:0] front, [63:32] rear, [64] is_empty,
                                   // [69:65] entry_count, [73:70] found_index
   logic [1:0]  rsp_tuser;         // [1:0] status

   fifo_queue_with_search #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // shadow queue
   logic [31:0] shadow_store [DEPTH];
   int          shadow_head = 0;
   int          shadow_tail = 0;
   int          shadow_occ  = 0;

   qresult_type  pending_results [$];
   stim_row_type stim_rows [$];
   int          mismatches  = 0;
   int          rsp_count   = 0;
   int          idle_cycles = 0;
   int          req_burst   = 0;
   int          rsp_burst   = 0;

   function automatic qresult_type queue_apply(op_type op, logic [31:0] val);
      qresult_type r;
      int       p;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_ENQUEUE: begin
            if (shadow_occ == DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_store[shadow_tail] = val;
               shadow_tail = (shadow_tail + 1) % DEPTH;
               shadow_occ++;
            end
         end
         OP_DEQUEUE: begin
            if (shadow_occ == 0) begin
               r.status = ST_EMPTY;
            end else begin
               shadow_head = (shadow_head + 1) % DEPTH;
               shadow_occ--;
            end
         end
         OP_SEARCH: begin
            if (shadow_occ == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.status = ST_NOTFOUND;
               for (int i = 0; i < shadow_occ; i++) begin
                  p = (shadow_head + i) % DEPTH;
                  if (shadow_store[p] == val) begin
                     r.status = ST_OK;
                     r.found  = i[3:0];
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      if (shadow_occ != 0) begin
         r.front = shadow_store[shadow_head];
         r.rear  = shadow_store[(shadow_tail + DEPTH - 1) % DEPTH];
      end
      r.is_empty = (shadow_occ == 0);
      r.count    = shadow_occ[4:0];
      return r;
   endfunction

   function automatic void add_row(op_type op, logic [31:0] value, bit typed,
                                   status_type st, logic [31:0] front,
                                   logic [31:0] rear, int cnt, int found);
      stim_row_type row;
      row.op            = op;
      row.value         = value;
      row.typed         = typed;
      row.want.status   = st;
      row.want.front    = front;
      row.want.rear     = rear;
      row.want.is_empty = (cnt == 0);
      row.want.count    = cnt[4:0];
      row.want.found    = found[3:0];
      stim_rows.push_back(row);
   endfunction

   // mostly short gaps, a few long ones, and now and then a burst with none
   function automatic int pick_gap(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         burst = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send(op_type op, logic [31:0] val, bit typed, qresult_type want);
      int          gap;
      qresult_type predicted;
      gap = pick_gap(req_burst);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= 2'($urandom_range(0, 3));
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      do @(posedge clock); while (!req_tready);
      predicted = queue_apply(op, val);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         if (mismatches < REPORT_MAX)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      qresult_type want_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (pending_results.size() == 0) begin
            if (mismatches < REPORT_MAX)
               $display("%0t: unexpected transfer, expected none, got status %0d",
                        $time, rsp_tuser);
            mismatches++;
         end else begin
            want_r = pending_results.pop_front();
            check_field("status", 32'(want_r.status), 32'(rsp_tuser));
            check_field("front_value", want_r.front, rsp_tdata[31:0]);
            check_field("rear_value", want_r.rear, rsp_tdata[63:32]);
            check_field("is_empty", 32'(want_r.is_empty), 32'(rsp_tdata[64]));
            check_field("entry_count", 32'(want_r.count), 32'(rsp_tdata[69:65]));
            check_field("found_index", 32'(want_r.found), 32'(rsp_tdata[73:70]));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // receiver; once, a long hold-off so the block backs up into the request side
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      forever begin
         if (!held && rsp_count >= HOLD_AFTER) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         stall = pick_gap(rsp_burst);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      op_type      op;
      logic [31:0] val;
      bit          filling;
      int          mode_left;
      int          r;
      int          idx;

      add_row(OP_DEQUEUE, 32'h0,         1, ST_EMPTY, 0, 0, 0, 0);
      add_row(OP_SEARCH,  32'h0,         1, ST_EMPTY, 0, 0, 0, 0);
      add_row(OP_NOP,     32'hFFFF_FFFF, 1, ST_OK,    0, 0, 0, 0);
      add_row(OP_ENQUEUE, MAX_POS,       1, ST_OK, MAX_POS, MAX_POS, 1, 0);
      add_row(OP_ENQUEUE, MIN_NEG,       1, ST_OK, MAX_POS, MIN_NEG, 2, 0);
      add_row(OP_ENQUEUE, 32'hFFFF_FFFF, 1, ST_OK, MAX_POS, 32'hFFFF_FFFF, 3, 0);
      add_row(OP_ENQUEUE, 32'h0,         1, ST_OK, MAX_POS, 32'h0, 4, 0);
      add_row(OP_SEARCH,  MIN_NEG,       1, ST_OK, MAX_POS, 32'h0, 4, 1);
      add_row(OP_SEARCH,  32'h0,         1, ST_OK, MAX_POS, 32'h0, 4, 3);
      add_row(OP_SEARCH,  32'h1234_5678, 1, ST_NOTFOUND, MAX_POS, 32'h0, 4, 0);
      add_row(OP_NOP,     32'h5555_5555, 0, ST_OK, 0, 0, 0, 0);
      for (int k = 4; k < DEPTH; k++)
         add_row(OP_ENQUEUE, 100 + k, 0, ST_OK, 0, 0, 0, 0);
      add_row(OP_ENQUEUE, 32'hDEAD_BEEF, 1, ST_FULL, MAX_POS, 115, 16, 0);
      add_row(OP_SEARCH,  115,           1, ST_OK,   MAX_POS, 115, 16, 15);
      add_row(OP_DEQUEUE, 32'hAAAA_AAAA, 0, ST_OK, 0, 0, 0, 0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i])
         send(stim_rows[i].op, stim_rows[i].value, stim_rows[i].typed, stim_rows[i].want);

      // alternate fill-heavy and drain-heavy stretches to hit full and empty often
      filling   = 1'b1;
      mode_left = $urandom_range(20, 60);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (mode_left == 0) begin
            filling   = !filling;
            mode_left = $urandom_range(20, 60);
         end
         mode_left--;
         r = $urandom_range(0, 99);
         if (r < 5)
            op = OP_NOP;
         else if (r < 30)
            op = OP_SEARCH;
         else if (r < 85)
            op = filling ? OP_ENQUEUE : OP_DEQUEUE;
         else
            op = filling ? OP_DEQUEUE : OP_ENQUEUE;

         r = $urandom_range(0, 99);
         if (op == OP_SEARCH && shadow_occ > 0 && r < 65) begin
            idx = $urandom_range(0, shadow_occ - 1);
            val = shadow_store[(shadow_head + idx) % DEPTH];
         end else if (r < 80 && r >= 40) begin
            // few distinct values, so duplicates test the first-match rule
            val = $urandom_range(0, 7);
         end else if (r < 90) begin
            case ($urandom_range(0, 3))
               0:       val = MAX_POS;
               1:       val = MIN_NEG;
               2:       val = 32'hFFFF_FFFF;
               default: val = 32'h0;
            endcase
         end else begin
            val = $urandom;
         end
         send(op, val, 1'b0, '0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: expected %0d more transfers, got none", $time,
                  pending_results.size());
         mismatches += pending_results.size();
      end

      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
